// ===== hdl/rges_pkg.sv =====
// Shared types for the random graph edge skipper: controller states and command/status groups.
package rges_pkg;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } rges_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // take a skip beat and form the new column
        logic step;   // move one row down: col -= row, row += 1
        logic emit;   // write the result into the output register
    } rges_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic live;      // row is below the node count
        logic walk;      // column is at least the row and row is live
        logic out_free;  // output register empty or being drained this cycle
    } rges_status_t;

endpackage

// ===== hdl/random_graph_edge_skipper_top.sv =====
// Top level of the random graph edge skipper: stream ports, controller and datapath.
//
// Each input beat carries one geometric skip and yields exactly one output beat: an edge
// (row, column) of the lower triangle, or a finished flag once the row has reached the node
// count. The walk steps across the k rows that the skip carries it over, then writes the
// result into the output register and returns to idle, where the next input beat is
// accepted; the row advance subtracts one row per cycle in a single wide subtractor. A new
// beat is accepted once the previous result sits in the output register, so a waiting
// result does not block the next walk; only the write of the next result waits for the
// output register to drain. node_count is to be written on the cfg channel only while no
// beat is in flight; the block itself does not enforce this. A finished walk resumes if
// node_count is raised again.
module random_graph_edge_skipper_top
    import rges_pkg::*;
#(
    parameter int NODE_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write: node_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // skip beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] skip_length
    // edge beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] edge_row, [63:32] edge_col
    output logic [1:0]  m_tuser    // [0] edge_valid, [1] finished
);

    rges_cmd_t    cmd;
    rges_status_t status;
    logic         edge_valid;
    logic         finished;
    logic [31:0]  edge_row;
    logic [31:0]  edge_col;

    assign cfg_ready = 1'b1;

    rges_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rges_dpath #(
        .NODE_WIDTH (NODE_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .skip_length (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .edge_valid  (edge_valid),
        .edge_row    (edge_row),
        .edge_col    (edge_col),
        .finished    (finished)
    );

    // Pack the output beat
    assign m_tdata = {edge_col, edge_row};
    assign m_tuser = {finished, edge_valid};

endmodule

// ===== hdl/rges_ctrl.sv =====
// Controller state machine of the random graph edge skipper.
module rges_ctrl
    import rges_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  rges_status_t status,
    output rges_cmd_t    cmd
);

    rges_state_t state_reg;
    rges_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decide next state and drive datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    // a finished walk keeps its state untouched
                    cmd.load   = status.live;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (status.walk)
                begin
                    cmd.step = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A beat is only taken while no walk is in progress
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == ST_IDLE)
        else $error("load issued outside idle");

    // A result is never written over one still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("emit while output register busy");

    // Stepping and emitting never coincide
    a_step_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.step && cmd.emit))
        else $error("step and emit together");

endmodule

// ===== hdl/rges_dpath.sv =====
// Datapath of the random graph edge skipper: node count, row/column walk and output register.
module rges_dpath
    import rges_pkg::*;
#(
    parameter int NODE_WIDTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic [31:0]  cfg_data,
    input  logic [31:0]  skip_length,
    input  rges_cmd_t    cmd,
    output rges_status_t status,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         edge_valid,
    output logic [31:0]  edge_row,
    output logic [31:0]  edge_col,
    output logic         finished
);

    // Stored column width, and a working width that holds column plus a full skip
    localparam int COL_BITS = NODE_WIDTH + 2;
    localparam int COL_WIDE = ((COL_BITS > 33) ? COL_BITS : 33) + 1;

    logic [31:0]                node_count_reg;
    logic [NODE_WIDTH-1:0]      row_reg;
    logic [NODE_WIDTH-1:0]      row_next;
    logic signed [COL_WIDE-1:0] col_reg;
    logic signed [COL_WIDE-1:0] col_next;
    logic                       out_valid_reg;
    logic                       edge_valid_reg;
    logic                       finished_reg;
    logic [31:0]                edge_row_reg;
    logic [31:0]                edge_col_reg;

    logic [NODE_WIDTH-1:0]      limit;
    logic signed [COL_WIDE-1:0] row_wide;
    logic signed [COL_WIDE-1:0] col_start;
    logic signed [COL_WIDE-1:0] col_diff;

    // Node count taken modulo the row width
    assign limit    = NODE_WIDTH'(node_count_reg);
    assign row_wide = COL_WIDE'($signed({1'b0, row_reg}));

    // New column: stored column sign-extended, plus one plus the skip
    assign col_start = COL_WIDE'($signed(col_reg[COL_BITS-1:0]))
                     + COL_WIDE'($signed({1'b0, skip_length})) + COL_WIDE'(1);
    assign col_diff  = col_reg - row_wide;

    assign status.live     = row_reg < limit;
    assign status.walk     = status.live && !col_diff[COL_WIDE-1];
    assign status.out_free = !out_valid_reg || out_ready;

    // Advance the walk
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.load)
        begin
            col_next = col_start;
        end
        else if (cmd.step)
        begin
            col_next = col_diff;
            row_next = row_reg + NODE_WIDTH'(1);
        end
    end

    // Hold configuration and walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 32'd2;
            row_reg        <= NODE_WIDTH'(1);
            col_reg        <= '1;
        end
        else
        begin
            if (cfg_valid)
            begin
                node_count_reg <= cfg_data;
            end
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Output beat valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            edge_valid_reg <= status.live;
            finished_reg   <= !status.live;
            edge_row_reg   <= status.live ? 32'(row_reg) : 32'd0;
            edge_col_reg   <= status.live ? 32'(col_reg) : 32'd0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign edge_valid = edge_valid_reg;
    assign finished   = finished_reg;
    assign edge_row   = edge_row_reg;
    assign edge_col   = edge_col_reg;

    // Each step moves exactly one row down
    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> row_reg == $past(row_reg) + NODE_WIDTH'(1))
        else $error("row did not advance by one");

    // An emitted edge lies strictly below the diagonal
    a_edge_lower: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.live) |-> (col_reg >= 0 && col_reg < row_wide))
        else $error("edge column outside lower triangle");

    // The row never moves past the node count while walking
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> row_reg <= limit)
        else $error("row stepped beyond node count");

endmodule
